/* hw/rtl/sehs_pkg.sv */
// ----------------------------------------------------------------------------
// sehs_pkg
// Widths, latencies and helpers shared by the spring edge energy/Hessian
// datapath and its square root and divider units.
// ----------------------------------------------------------------------------
package sehs_pkg;

  localparam int IW   = 10;  // endpoint index
  localparam int CW   = 24;  // Q7.16 coordinate and result fields
  localparam int RW   = 23;  // rest length
  localparam int EW   = 39;  // energy
  localparam int DW   = 25;  // coordinate difference
  localparam int SQW  = 51;  // sum of squares
  localparam int LENW = 26;  // edge length
  localparam int SW   = 27;  // stretch, signed
  localparam int NUMW = 51;  // divider numerator, signed
  localparam int QW   = 26;  // divider quotient, signed, clamped to +-2^24
  localparam int UW   = 18;  // unit direction component, signed
  localparam int PW   = 18;  // projector entry, signed
  localparam int DMPW = 19;  // diagonal minus projector, signed

  localparam int DIV_QBITS  = 24;
  localparam int DIV_LAT    = DIV_QBITS + 2;
  localparam int SQRT_STEPS = 26;
  localparam int SQRT_LAT   = SQRT_STEPS;

  localparam int ONE_Q16 = 65536;

  function automatic logic signed [CW-1:0] sat24(input logic signed [27:0] v);
    logic signed [CW-1:0] r;
    if (v > 28'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -28'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/spring_edge_energy_hessian.sv */
// ----------------------------------------------------------------------------
// spring_edge_energy_hessian
// Energy, gradient and six local Hessian entries of one harmonic spring edge.
// ----------------------------------------------------------------------------
// One edge enters every cycle and each result is flagged by out_valid high for
// one cycle; busy is always low. The pipeline runs through the 26-stage square
// root and two 26-stage dividers (direction and force first, Hessian correction
// second). A zero-length edge gives zero force and Hessian.
module spring_edge_energy_hessian (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [sehs_pkg::IW-1:0]          in_point_a_index,
  input  logic [sehs_pkg::IW-1:0]          in_point_b_index,
  input  logic signed [sehs_pkg::CW-1:0]   in_point_a_x,
  input  logic signed [sehs_pkg::CW-1:0]   in_point_a_y,
  input  logic signed [sehs_pkg::CW-1:0]   in_point_a_z,
  input  logic signed [sehs_pkg::CW-1:0]   in_point_b_x,
  input  logic signed [sehs_pkg::CW-1:0]   in_point_b_y,
  input  logic signed [sehs_pkg::CW-1:0]   in_point_b_z,
  input  logic [sehs_pkg::RW-1:0]          in_rest_length,
  output logic                             out_valid,
  output logic [sehs_pkg::IW-1:0]          out_a_index,
  output logic [sehs_pkg::IW-1:0]          out_b_index,
  output logic [sehs_pkg::EW-1:0]          out_edge_energy,
  output logic signed [sehs_pkg::CW-1:0]   out_force_x,
  output logic signed [sehs_pkg::CW-1:0]   out_force_y,
  output logic signed [sehs_pkg::CW-1:0]   out_force_z,
  output logic signed [sehs_pkg::CW-1:0]   out_hess_xx,
  output logic signed [sehs_pkg::CW-1:0]   out_hess_xy,
  output logic signed [sehs_pkg::CW-1:0]   out_hess_xz,
  output logic signed [sehs_pkg::CW-1:0]   out_hess_yy,
  output logic signed [sehs_pkg::CW-1:0]   out_hess_yz,
  output logic signed [sehs_pkg::CW-1:0]   out_hess_zz
);
  import sehs_pkg::*;

  typedef struct packed {
    logic [IW-1:0]        ia;
    logic [IW-1:0]        ib;
    logic [RW-1:0]        rest;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
  } geo_t;

  typedef struct packed {
    logic [IW-1:0]        ia;
    logic [IW-1:0]        ib;
    logic [EW-1:0]        energy;
    logic signed [SW-1:0] s;
    logic [LENW-1:0]      len;
    logic                 zero;
  } mid_t;

  typedef struct packed {
    logic [IW-1:0]        ia;
    logic [IW-1:0]        ib;
    logic [EW-1:0]        energy;
    logic                 zero;
    logic signed [CW-1:0] fx;
    logic signed [CW-1:0] fy;
    logic signed [CW-1:0] fz;
    logic signed [PW-1:0] p0;
    logic signed [PW-1:0] p1;
    logic signed [PW-1:0] p2;
    logic signed [PW-1:0] p3;
    logic signed [PW-1:0] p4;
    logic signed [PW-1:0] p5;
  } tail_t;

  assign busy = 1'b0;

  // ---- stage 1: differences
  logic                 v1_r;
  geo_t                 g1_r, g1_nxt;

  always_comb begin
    g1_nxt.ia   = in_point_a_index;
    g1_nxt.ib   = in_point_b_index;
    g1_nxt.rest = in_rest_length;
    g1_nxt.dx   = $signed({in_point_b_x[CW-1], in_point_b_x})
                - $signed({in_point_a_x[CW-1], in_point_a_x});
    g1_nxt.dy   = $signed({in_point_b_y[CW-1], in_point_b_y})
                - $signed({in_point_a_y[CW-1], in_point_a_y});
    g1_nxt.dz   = $signed({in_point_b_z[CW-1], in_point_b_z})
                - $signed({in_point_a_z[CW-1], in_point_a_z});
  end

  // ---- stage 2: squares
  logic                 v2_r;
  geo_t                 g2_r;
  logic [2*DW-1:0]      sqx2_r, sqy2_r, sqz2_r;
  logic signed [2*DW-1:0] sqx, sqy, sqz;

  always_comb begin
    sqx = g1_r.dx * g1_r.dx;
    sqy = g1_r.dy * g1_r.dy;
    sqz = g1_r.dz * g1_r.dz;
  end

  // ---- stage 3: sum of squares
  logic                 v3_r;
  geo_t                 g3_r;
  logic [SQW-1:0]       sq3_r;

  // ---- square root with aligned side data
  logic [LENW-1:0]      len_sq;
  logic [SQRT_LAT-1:0]  vs_r;
  geo_t                 gs_r [SQRT_LAT];

  sehs_sqrt u_sqrt (
    .clk (clk),
    .x   (sq3_r),
    .len (len_sq)
  );

  // ---- stage A: stretch
  logic                 vA_r;
  geo_t                 gA_r;
  logic [LENW-1:0]      lenA_r;
  logic signed [SW-1:0] sA_r;

  // ---- stage B: products feeding the first divider bank
  logic                 vB_r;
  logic [IW-1:0]        iaB_r, ibB_r;
  logic signed [SW-1:0] sB_r;
  logic [LENW-1:0]      lenB_r;
  logic                 zeroB_r;
  logic [2*SW-1:0]      ssB_r;
  logic signed [NUMW-1:0] nfx_r, nfy_r, nfz_r, nux_r, nuy_r, nuz_r;
  logic signed [2*SW-1:0] ss_p;
  logic signed [SW+DW-1:0] fpx, fpy, fpz;

  always_comb begin
    ss_p = sA_r * sA_r;
    fpx  = sA_r * gA_r.dx;
    fpy  = sA_r * gA_r.dy;
    fpz  = sA_r * gA_r.dz;
  end

  logic signed [QW-1:0] qfx, qfy, qfz, qux, quy, quz;

  sehs_div u_div_fx (.clk(clk), .num(nfx_r), .den(lenB_r), .quo(qfx));
  sehs_div u_div_fy (.clk(clk), .num(nfy_r), .den(lenB_r), .quo(qfy));
  sehs_div u_div_fz (.clk(clk), .num(nfz_r), .den(lenB_r), .quo(qfz));
  sehs_div u_div_ux (.clk(clk), .num(nux_r), .den(lenB_r), .quo(qux));
  sehs_div u_div_uy (.clk(clk), .num(nuy_r), .den(lenB_r), .quo(quy));
  sehs_div u_div_uz (.clk(clk), .num(nuz_r), .den(lenB_r), .quo(quz));

  mid_t                 mB;
  logic [DIV_LAT-1:0]   vm_r;
  mid_t                 m_r [DIV_LAT];

  always_comb begin
    mB.ia     = iaB_r;
    mB.ib     = ibB_r;
    mB.energy = EW'(ssB_r >> 17);
    mB.s      = sB_r;
    mB.len    = lenB_r;
    mB.zero   = zeroB_r;
  end

  // ---- stage C: force saturation and projector products
  logic                 vC_r;
  mid_t                 mC_r;
  logic signed [CW-1:0] fxC_r, fyC_r, fzC_r;
  logic signed [2*UW-1:0] pC_r [6];
  logic signed [UW-1:0] ux, uy, uz;

  always_comb begin
    ux = qux[UW-1:0];
    uy = quy[UW-1:0];
    uz = quz[UW-1:0];
  end

  // ---- stage D: scale projector back to Q16, form diagonal minus projector
  logic                 vD_r;
  mid_t                 mD_r;
  logic signed [CW-1:0] fxD_r, fyD_r, fzD_r;
  logic signed [PW-1:0] pD_r [6];
  logic signed [DMPW-1:0] dmpD_r [6];
  logic signed [PW-1:0] pt [6];
  logic signed [DMPW-1:0] dmp [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      // round toward zero on negative products
      if (pC_r[k][2*UW-1]) begin
        pt[k] = PW'((pC_r[k] + (2*UW)'(ONE_Q16 - 1)) >>> 16);
      end else begin
        pt[k] = PW'(pC_r[k] >>> 16);
      end
      if (k == 0 || k == 3 || k == 5) begin
        dmp[k] = DMPW'(ONE_Q16) - DMPW'(pt[k]);
      end else begin
        dmp[k] = -DMPW'(pt[k]);
      end
    end
  end

  // ---- stage E: stretch times correction, into the second divider bank
  logic                 vE_r;
  mid_t                 mE_r;
  logic signed [CW-1:0] fxE_r, fyE_r, fzE_r;
  logic signed [PW-1:0] pE_r [6];
  logic signed [SW+DMPW-1:0] mulE_r [6];
  logic signed [SW+DMPW-1:0] mul_p [6];
  logic signed [QW-1:0] qh [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      mul_p[k] = mD_r.s * dmpD_r[k];
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_hdiv
    sehs_div u_div_h (
      .clk (clk),
      .num ({{(NUMW-SW-DMPW){mulE_r[g][SW+DMPW-1]}}, mulE_r[g]}),
      .den (mE_r.len),
      .quo (qh[g])
    );
  end

  tail_t                tE;
  logic [DIV_LAT-1:0]   vt_r;
  tail_t                t_r [DIV_LAT];

  always_comb begin
    tE.ia     = mE_r.ia;
    tE.ib     = mE_r.ib;
    tE.energy = mE_r.energy;
    tE.zero   = mE_r.zero;
    tE.fx     = fxE_r;
    tE.fy     = fyE_r;
    tE.fz     = fzE_r;
    tE.p0     = pE_r[0];
    tE.p1     = pE_r[1];
    tE.p2     = pE_r[2];
    tE.p3     = pE_r[3];
    tE.p4     = pE_r[4];
    tE.p5     = pE_r[5];
  end

  // ---- stage F: final sum and output register
  tail_t                tF;
  logic signed [CW-1:0] h_nxt [6];
  logic signed [PW-1:0] pF [6];

  always_comb begin
    tF    = t_r[DIV_LAT-1];
    pF[0] = tF.p0;
    pF[1] = tF.p1;
    pF[2] = tF.p2;
    pF[3] = tF.p3;
    pF[4] = tF.p4;
    pF[5] = tF.p5;
    for (int k = 0; k < 6; k++) begin
      h_nxt[k] = tF.zero ? '0 : sat24(28'(pF[k]) + 28'(qh[k]));
    end
  end

  logic                 out_valid_r;
  logic [IW-1:0]        out_a_r, out_b_r;
  logic [EW-1:0]        out_e_r;
  logic signed [CW-1:0] out_f_r [3];
  logic signed [CW-1:0] out_h_r [6];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      vs_r        <= '0;
      vA_r        <= 1'b0;
      vB_r        <= 1'b0;
      vm_r        <= '0;
      vC_r        <= 1'b0;
      vD_r        <= 1'b0;
      vE_r        <= 1'b0;
      vt_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= start & ~busy;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      vs_r        <= {vs_r[SQRT_LAT-2:0], v3_r};
      vA_r        <= vs_r[SQRT_LAT-1];
      vB_r        <= vA_r;
      vm_r        <= {vm_r[DIV_LAT-2:0], vB_r};
      vC_r        <= vm_r[DIV_LAT-1];
      vD_r        <= vC_r;
      vE_r        <= vD_r;
      vt_r        <= {vt_r[DIV_LAT-2:0], vE_r};
      out_valid_r <= vt_r[DIV_LAT-1];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    g1_r   <= g1_nxt;

    g2_r   <= g1_r;
    sqx2_r <= sqx;
    sqy2_r <= sqy;
    sqz2_r <= sqz;

    g3_r   <= g2_r;
    sq3_r  <= SQW'(sqx2_r) + SQW'(sqy2_r) + SQW'(sqz2_r);

    gs_r[0] <= g3_r;
    for (int k = 1; k < SQRT_LAT; k++) begin
      gs_r[k] <= gs_r[k-1];
    end

    gA_r   <= gs_r[SQRT_LAT-1];
    lenA_r <= len_sq;
    sA_r   <= $signed({1'b0, len_sq}) - $signed({{(SW-RW){1'b0}}, gs_r[SQRT_LAT-1].rest});

    iaB_r   <= gA_r.ia;
    ibB_r   <= gA_r.ib;
    sB_r    <= sA_r;
    lenB_r  <= lenA_r;
    zeroB_r <= (lenA_r == '0);
    ssB_r   <= ss_p[2*SW-1:0];
    nfx_r   <= fpx[NUMW-1:0];
    nfy_r   <= fpy[NUMW-1:0];
    nfz_r   <= fpz[NUMW-1:0];
    nux_r   <= {{(NUMW-DW-16){gA_r.dx[DW-1]}}, gA_r.dx, 16'b0};
    nuy_r   <= {{(NUMW-DW-16){gA_r.dy[DW-1]}}, gA_r.dy, 16'b0};
    nuz_r   <= {{(NUMW-DW-16){gA_r.dz[DW-1]}}, gA_r.dz, 16'b0};

    m_r[0] <= mB;
    for (int k = 1; k < DIV_LAT; k++) begin
      m_r[k] <= m_r[k-1];
    end

    mC_r     <= m_r[DIV_LAT-1];
    fxC_r    <= sat24(28'(qfx));
    fyC_r    <= sat24(28'(qfy));
    fzC_r    <= sat24(28'(qfz));
    pC_r[0]  <= ux * ux;
    pC_r[1]  <= ux * uy;
    pC_r[2]  <= ux * uz;
    pC_r[3]  <= uy * uy;
    pC_r[4]  <= uy * uz;
    pC_r[5]  <= uz * uz;

    mD_r  <= mC_r;
    fxD_r <= fxC_r;
    fyD_r <= fyC_r;
    fzD_r <= fzC_r;
    for (int k = 0; k < 6; k++) begin
      pD_r[k]   <= pt[k];
      dmpD_r[k] <= dmp[k];
    end

    mE_r  <= mD_r;
    fxE_r <= fxD_r;
    fyE_r <= fyD_r;
    fzE_r <= fzD_r;
    for (int k = 0; k < 6; k++) begin
      pE_r[k]   <= pD_r[k];
      mulE_r[k] <= mul_p[k];
    end

    t_r[0] <= tE;
    for (int k = 1; k < DIV_LAT; k++) begin
      t_r[k] <= t_r[k-1];
    end

    out_a_r    <= tF.ia;
    out_b_r    <= tF.ib;
    out_e_r    <= tF.energy;
    out_f_r[0] <= tF.zero ? '0 : tF.fx;
    out_f_r[1] <= tF.zero ? '0 : tF.fy;
    out_f_r[2] <= tF.zero ? '0 : tF.fz;
    for (int k = 0; k < 6; k++) begin
      out_h_r[k] <= h_nxt[k];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_a_index     = out_a_r;
  assign out_b_index     = out_b_r;
  assign out_edge_energy = out_e_r;
  assign out_force_x     = out_f_r[0];
  assign out_force_y     = out_f_r[1];
  assign out_force_z     = out_f_r[2];
  assign out_hess_xx     = out_h_r[0];
  assign out_hess_xy     = out_h_r[1];
  assign out_hess_xz     = out_h_r[2];
  assign out_hess_yy     = out_h_r[3];
  assign out_hess_yz     = out_h_r[4];
  assign out_hess_zz     = out_h_r[5];

endmodule

/* hw/rtl/sehs_sqrt.sv */
// ----------------------------------------------------------------------------
// sehs_sqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module sehs_sqrt (
  input  logic                       clk,
  input  logic [sehs_pkg::SQW-1:0]   x,
  output logic [sehs_pkg::LENW-1:0]  len
);
  import sehs_pkg::*;

  localparam int RESW = SQW + 1;

  logic [RESW-1:0] x_r   [SQRT_STEPS];
  logic [RESW-1:0] res_r [SQRT_STEPS];

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    logic [RESW-1:0] x_in, res_in, bitv, trial, x_nxt, res_nxt;

    if (g == 0) begin : g_first
      assign x_in   = RESW'(x);
      assign res_in = '0;
    end else begin : g_next
      assign x_in   = x_r[g-1];
      assign res_in = res_r[g-1];
    end

    always_comb begin
      bitv  = RESW'(1) << (2 * (SQRT_STEPS - 1 - g));
      trial = res_in + bitv;
      if (x_in >= trial) begin
        x_nxt   = x_in - trial;
        res_nxt = (res_in >> 1) + bitv;
      end else begin
        x_nxt   = x_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      x_r[g]   <= x_nxt;
      res_r[g] <= res_nxt;
    end
  end

  assign len = res_r[SQRT_STEPS-1][LENW-1:0];

endmodule

/* hw/rtl/sehs_div.sv */
// ----------------------------------------------------------------------------
// sehs_div
// Pipelined signed divider rounding toward zero, one quotient bit per stage.
// A quotient of magnitude 2^24 or more comes out clamped to +-2^24.
// ----------------------------------------------------------------------------
module sehs_div (
  input  logic                              clk,
  input  logic signed [sehs_pkg::NUMW-1:0]  num,
  input  logic [sehs_pkg::LENW-1:0]         den,
  output logic signed [sehs_pkg::QW-1:0]    quo
);
  import sehs_pkg::*;

  logic                 neg0_r, sat0_r;
  logic [NUMW-1:0]      rem0_r;
  logic [LENW-1:0]      den0_r;

  logic                 neg_r [DIV_QBITS];
  logic                 sat_r [DIV_QBITS];
  logic [NUMW-1:0]      rem_r [DIV_QBITS];
  logic [LENW-1:0]      den_r [DIV_QBITS];
  logic [DIV_QBITS-1:0] q_r   [DIV_QBITS];

  logic signed [QW-1:0] quo_r;
  logic [NUMW-1:0]      mag;

  always_comb begin
    mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
  end

  // flag overflow up front so only the low quotient bits need computing
  always_ff @(posedge clk) begin
    neg0_r <= num[NUMW-1];
    rem0_r <= mag;
    den0_r <= den;
    sat0_r <= mag >= (NUMW'(den) << DIV_QBITS);
  end

  for (genvar g = 0; g < DIV_QBITS; g++) begin : g_step
    logic                 neg_in, sat_in, ge;
    logic [NUMW-1:0]      rem_in, dsh;
    logic [LENW-1:0]      den_in;
    logic [DIV_QBITS-1:0] q_in;

    if (g == 0) begin : g_first
      assign neg_in = neg0_r;
      assign sat_in = sat0_r;
      assign rem_in = rem0_r;
      assign den_in = den0_r;
      assign q_in   = '0;
    end else begin : g_next
      assign neg_in = neg_r[g-1];
      assign sat_in = sat_r[g-1];
      assign rem_in = rem_r[g-1];
      assign den_in = den_r[g-1];
      assign q_in   = q_r[g-1];
    end

    always_comb begin
      dsh = NUMW'(den_in) << (DIV_QBITS - 1 - g);
      ge  = rem_in >= dsh;
    end

    always_ff @(posedge clk) begin
      neg_r[g] <= neg_in;
      sat_r[g] <= sat_in;
      den_r[g] <= den_in;
      rem_r[g] <= ge ? rem_in - dsh : rem_in;
      q_r[g]   <= {q_in[DIV_QBITS-2:0], ge};
    end
  end

  logic [QW-1:0] magq;

  always_comb begin
    magq = sat_r[DIV_QBITS-1] ? (QW'(1) << DIV_QBITS) : QW'(q_r[DIV_QBITS-1]);
  end

  always_ff @(posedge clk) begin
    quo_r <= neg_r[DIV_QBITS-1] ? -$signed(magq) : $signed(magq);
  end

  assign quo = quo_r;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spring edge energy/Hessian testbench
// Drives spring edges through a directed table and then random traffic,
// predicts energy, force and Hessian in integer arithmetic and checks every
// result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import sehs_pkg::*;

  localparam int NUM_RANDOM = 1800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [EW-1:0] ENERGY_CAP = 39'h7F_FFFF_FFFF;

  typedef struct packed {
    logic [IW-1:0] a_idx;
    logic [IW-1:0] b_idx;
    logic signed [CW-1:0] ax, ay, az, bx, by, bz;
    logic [RW-1:0] rest;
  } edge_t;

  typedef struct packed {
    logic [IW-1:0] a_idx;
    logic [IW-1:0] b_idx;
    logic [EW-1:0] energy;
    logic signed [CW-1:0] fx, fy, fz;
    logic signed [CW-1:0] hxx, hxy, hxz, hyy, hyz, hzz;
  } spring_res_t;

  typedef struct {
    edge_t e;
    bit has_known;
    spring_res_t known;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  edge_t drv = '0;
  logic out_valid;
  spring_res_t got;

  spring_res_t pending_results[$];
  spring_res_t known_results[$];
  bit known_flags[$];
  int mismatches = 0;
  longint cycles = 0;

  always #6 clk = ~clk;

  spring_edge_energy_hessian dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_a_index(drv.a_idx), .in_point_b_index(drv.b_idx),
    .in_point_a_x(drv.ax), .in_point_a_y(drv.ay), .in_point_a_z(drv.az),
    .in_point_b_x(drv.bx), .in_point_b_y(drv.by), .in_point_b_z(drv.bz),
    .in_rest_length(drv.rest),
    .out_valid(out_valid), .out_a_index(got.a_idx), .out_b_index(got.b_idx),
    .out_edge_energy(got.energy),
    .out_force_x(got.fx), .out_force_y(got.fy), .out_force_z(got.fz),
    .out_hess_xx(got.hxx), .out_hess_xy(got.hxy), .out_hess_xz(got.hxz),
    .out_hess_yy(got.hyy), .out_hess_yz(got.hyz), .out_hess_zz(got.hzz)
  );

  function automatic logic signed [CW-1:0] clamp24(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[CW-1:0];
  endfunction

  function automatic longint floor_sqrt(input longint x);
    longint r, b;
    r = 0;
    b = 64'sd1 << 60;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic spring_res_t spring_response(input edge_t e);
    spring_res_t r;
    longint d[3], u[3], h[6];
    longint sq, len, s, en, p, dg;
    int ri[6] = '{0, 0, 0, 1, 1, 2};
    int ci[6] = '{0, 1, 2, 1, 2, 2};
    r = '0;
    d[0] = longint'(e.bx) - longint'(e.ax);
    d[1] = longint'(e.by) - longint'(e.ay);
    d[2] = longint'(e.bz) - longint'(e.az);
    sq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    len = floor_sqrt(sq);
    s = len - longint'({1'b0, e.rest});
    en = (s * s) >>> 17;
    r.a_idx = e.a_idx;
    r.b_idx = e.b_idx;
    r.energy = (en > longint'(ENERGY_CAP)) ? ENERGY_CAP : en[EW-1:0];
    if (len == 0) return r;
    for (int i = 0; i < 3; i++) u[i] = (d[i] * 65536) / len;
    r.fx = clamp24((s * d[0]) / len);
    r.fy = clamp24((s * d[1]) / len);
    r.fz = clamp24((s * d[2]) / len);
    for (int k = 0; k < 6; k++) begin
      p = (u[ri[k]] * u[ci[k]]) / 65536;
      dg = (ri[k] == ci[k]) ? 65536 : 0;
      h[k] = p + (s * (dg - p)) / len;
    end
    r.hxx = clamp24(h[0]); r.hxy = clamp24(h[1]); r.hxz = clamp24(h[2]);
    r.hyy = clamp24(h[3]); r.hyz = clamp24(h[4]); r.hzz = clamp24(h[5]);
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return CW'($urandom);
      1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: return 24'($signed($urandom_range(0, 2 * 262144)) - 262144);
    endcase
  endfunction

  function automatic edge_t rand_edge();
    edge_t e;
    e.a_idx = IW'($urandom);
    e.b_idx = $urandom_range(0, 7) == 0 ? e.a_idx : IW'($urandom);
    e.ax = rand_coord(); e.ay = rand_coord(); e.az = rand_coord();
    case ($urandom_range(0, 9))
      0: begin e.bx = e.ax; e.by = e.ay; e.bz = e.az; end
      1: begin
        e.bx = e.ax + 24'($signed($urandom_range(0, 6)) - 3);
        e.by = e.ay + 24'($signed($urandom_range(0, 6)) - 3);
        e.bz = e.az;
      end
      default: begin e.bx = rand_coord(); e.by = rand_coord(); e.bz = rand_coord(); end
    endcase
    case ($urandom_range(0, 3))
      0: e.rest = RW'($urandom);
      1: e.rest = $urandom_range(0, 1) ? '1 : '0;
      default: e.rest = RW'($urandom_range(0, 400000));
    endcase
    return e;
  endfunction

  // Called at a falling edge; start stays high across back-to-back transactions.
  task automatic send_edge(input edge_t e, input bit has_known, input spring_res_t k);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    drv <= e;
    start <= 1'b1;
    pending_results = {pending_results, spring_response(e)};
    known_results = {known_results, k};
    known_flags = {known_flags, has_known};
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic report(input string what, input spring_res_t exp, input spring_res_t act);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected %p actual %p", what, exp, act);
  endtask

  // Check each transaction against the predictor and any typed-in value.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      spring_res_t exp, k;
      bit kf;
      if (pending_results.size() == 0) begin
        report("unexpected", '0, got);
      end else begin
        exp = pending_results.pop_front();
        k = known_results.pop_front();
        kf = known_flags.pop_front();
        if (got.a_idx !== exp.a_idx || got.b_idx !== exp.b_idx ||
            got.energy !== exp.energy || got.fx !== exp.fx ||
            got.fy !== exp.fy || got.fz !== exp.fz ||
            got.hxx !== exp.hxx || got.hxy !== exp.hxy ||
            got.hxz !== exp.hxz || got.hyy !== exp.hyy ||
            got.hyz !== exp.hyz || got.hzz !== exp.hzz)
          report("predicted", exp, got);
        if (kf && got !== k) report("table", k, got);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t row;
    spring_res_t z;
    z = '0;
    // Zero-length edges: energy is half the rest length squared, zero when rest is zero.
    row.e = '{10'd0, 10'd0, 0, 0, 0, 0, 0, 0, 23'd0};
    row.has_known = 1; row.known = z; rows = {rows, row};
    row.e = '{10'd1023, 10'd1023, 24'sh7FFFFF, 24'sh800000, 0,
              24'sh7FFFFF, 24'sh800000, 0, 23'h7FFFFF};
    row.known = z; row.known.a_idx = 10'd1023; row.known.b_idx = 10'd1023;
    row.known.energy = EW'((64'h7FFFFF * 64'h7FFFFF) >> 17);
    rows = {rows, row};
    // Unit edge along x, rest 1.0: Hessian is the projector onto x.
    row.e = '{10'd5, 10'd6, 0, 0, 0, 24'sd65536, 0, 0, 23'd65536};
    row.known = z; row.known.a_idx = 10'd5; row.known.b_idx = 10'd6;
    row.known.hxx = 24'sd65536; rows = {rows, row};
    row.has_known = 0;
    row.e = '{10'd3, 10'd900, 24'sh800000, 24'sh800000, 24'sh800000,
              24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 23'd0}; rows = {rows, row};
    row.e = '{10'd7, 10'd8, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
              24'sh800000, 24'sh800000, 24'sh800000, 23'h7FFFFF}; rows = {rows, row};
    row.e = '{10'd9, 10'd10, 0, 0, 0, 0, 24'sd1, 0, 23'h7FFFFF}; rows = {rows, row};
    row.e = '{10'd11, 10'd12, 24'sd100, 24'sd200, 24'sd300,
              24'sd70000, 24'sd200, -24'sd90000, 23'd1000}; rows = {rows, row};
    row.e = '{10'd13, 10'd14, 0, 0, 0, 24'sd1, 24'sd1, 24'sd1, 23'd0}; rows = {rows, row};
    row.e = '{10'd15, 10'd16, 0, 0, 0, 24'sd300000, 24'sd300000, 24'sd300000,
              23'd1}; rows = {rows, row};
    row.e = '{10'd512, 10'd511, 24'sh555555, -24'sd1, 24'sh2AAAAA,
              24'sh2AAAAA, 24'sh555555, -24'sd1, 23'h555555}; rows = {rows, row};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) send_edge(rows[i].e, rows[i].has_known, rows[i].known);
    for (int n = 0; n < NUM_RANDOM; n++) send_edge(rand_edge(), 0, z);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* spring_edge_energy_hessian.f */
hw/rtl/sehs_pkg.sv
hw/rtl/sehs_sqrt.sv
hw/rtl/sehs_div.sv
hw/rtl/spring_edge_energy_hessian.sv
test/tb_top.sv
